[hdl/utf8_lenient_decoder_unit_defines.svh]
// assertion macros for the lenient utf-8 decoder
// expects clk and arst_n in the scope of each use
`ifndef UTF8_LENIENT_DECODER_UNIT_DEFINES_SVH
`define UTF8_LENIENT_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define U8LD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("utf8 decoder check failed");
`define U8LD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("utf8 decoder check failed");
`else
`define U8LD_ASSERT_NOW(label, ante, cons)
`define U8LD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/u8ld_pkg.sv]
// types, constants and decode functions of the lenient utf-8 decoder
// no dependencies
package u8ld_pkg;

	localparam logic [20:0] QMARK = 21'd63;

	localparam logic [2:0] LEN_BAD = 3'd0;
	localparam logic [2:0] LEN_ONE = 3'd1;
	localparam logic [2:0] LEN_TWO = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} byte_item_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        run_last;
		logic        text_finished;
	} cp_item_t;

	typedef logic [3:0][7:0] byte_win_t;

	typedef enum logic {
		ST_IDLE,
		ST_FLUSH
	} state_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		len = LEN_BAD;
		if ((b & 8'h80) == 8'h00) len = LEN_ONE;
		else if ((b & 8'hE0) == 8'hC0) len = LEN_TWO;
		else if ((b & 8'hF0) == 8'hE0) len = LEN_THREE;
		else if ((b & 8'hF8) == 8'hF0) len = LEN_FOUR;
		return len;
	endfunction

	function automatic logic [20:0] assemble(input byte_win_t w, input logic [2:0] len);
		logic [20:0] cp;
		unique case (len)
			LEN_ONE:   cp = {13'd0, w[0]};
			LEN_TWO:   cp = {10'd0, w[0][4:0], w[1][5:0]};
			LEN_THREE: cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
			LEN_FOUR:  cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
			default:   cp = QMARK;
		endcase
		return cp;
	endfunction

endpackage

[hdl/utf8_lenient_decoder_unit.sv]
// lenient utf-8 decoder: bytes in, code points out
// depends on u8ld_pkg and utf8_lenient_decoder_unit_defines.svh
//
//  channel   dir  payload        handshake
//  byte      in   byte_item_t    byte_valid / byte_stall
//  cp        out  cp_item_t      cp_valid / cp_stall
//
// a byte without end_of_text is taken when the output register is free; a completed sequence gives one result
// a byte with end_of_text is taken likewise, then the held bytes give one to four results,
// each produced by the shared decode unit over the held bytes
// reset clears the sequencer and the output valid flag; held bytes need no clearing
// results wait in an output register; a stalled result holds the sequencer

`include "utf8_lenient_decoder_unit_defines.svh"

module utf8_lenient_decoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  u8ld_pkg::byte_item_t byte_item,
	output logic                cp_valid,
	input  logic                cp_stall,
	output u8ld_pkg::cp_item_t  cp_item
);

	u8ld_pkg::state_t    state_q, state_d;
	logic [1:0]          cnt_q, cnt_d;
	logic [2:0]          len_q, len_d;
	logic [2:0]          rem_q, rem_d;
	u8ld_pkg::byte_win_t buf_q, buf_d;
	logic                cp_valid_q;
	u8ld_pkg::cp_item_t  cp_item_q;

	u8ld_pkg::byte_win_t win_idle, unit_win;
	logic [2:0]          unit_len, lead_in, lead_buf, step, n_in;
	logic [20:0]         unit_cp;
	logic                flush_ok, out_free, load, last;
	u8ld_pkg::cp_item_t  load_item;

	assign out_free = !cp_valid_q || !cp_stall;
	assign lead_in  = u8ld_pkg::lead_length(byte_item.text_byte);
	assign lead_buf = u8ld_pkg::lead_length(buf_q[0]);
	assign flush_ok = (lead_buf != u8ld_pkg::LEN_BAD) && (lead_buf <= rem_q);
	assign step     = flush_ok ? lead_buf : 3'd1;
	assign last     = (step == rem_q);
	assign n_in     = {1'b0, cnt_q} + 3'd1;

	always_comb begin
		win_idle = buf_q;
		win_idle[cnt_q] = byte_item.text_byte;
	end

	// shared decode unit operand select
	always_comb begin
		unit_win = buf_q;
		unit_len = u8ld_pkg::LEN_BAD;
		unique case (state_q)
			u8ld_pkg::ST_IDLE: begin
				unit_win = win_idle;
				unit_len = (cnt_q == 2'd0) ? lead_in : len_q;
			end
			u8ld_pkg::ST_FLUSH: begin
				unit_len = flush_ok ? lead_buf : u8ld_pkg::LEN_BAD;
			end
			default: begin
				unit_len = u8ld_pkg::LEN_BAD;
			end
		endcase
	end

	assign unit_cp = u8ld_pkg::assemble(unit_win, unit_len);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		len_d      = len_q;
		rem_d      = rem_q;
		buf_d      = buf_q;
		load       = 1'b0;
		load_item  = '0;
		byte_stall = 1'b1;
		unique case (state_q)
			u8ld_pkg::ST_IDLE: begin
				byte_stall = !out_free;
				if (byte_valid && out_free) begin
					if (byte_item.end_of_text) begin
						buf_d   = win_idle;
						rem_d   = n_in;
						cnt_d   = 2'd0;
						len_d   = u8ld_pkg::LEN_BAD;
						state_d = u8ld_pkg::ST_FLUSH;
					end else if (cnt_q == 2'd0 && lead_in > u8ld_pkg::LEN_ONE) begin
						buf_d = win_idle;
						cnt_d = 2'd1;
						len_d = lead_in;
					end else if (cnt_q != 2'd0 && n_in < len_q) begin
						buf_d = win_idle;
						cnt_d = n_in[1:0];
					end else begin
						load      = 1'b1;
						load_item = '{code_point: unit_cp, run_last: 1'b1,
							text_finished: 1'b0};
						cnt_d     = 2'd0;
						len_d     = u8ld_pkg::LEN_BAD;
					end
				end
			end
			u8ld_pkg::ST_FLUSH: begin
				if (out_free) begin
					load      = 1'b1;
					load_item = '{code_point: unit_cp, run_last: last, text_finished: last};
					buf_d     = buf_q >> {step, 3'b000};
					rem_d     = rem_q - step;
					if (last) begin
						state_d = u8ld_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = u8ld_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= u8ld_pkg::ST_IDLE;
			cnt_q      <= 2'd0;
			len_q      <= u8ld_pkg::LEN_BAD;
			rem_q      <= 3'd0;
			cp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			if (load) begin
				cp_valid_q <= 1'b1;
			end else if (!cp_stall) begin
				cp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		buf_q <= buf_d;
		if (load) begin
			cp_item_q <= load_item;
		end
	end

	assign cp_valid = cp_valid_q;
	assign cp_item  = cp_item_q;

	`U8LD_ASSERT_NOW(a_flush_rem, state_q == u8ld_pkg::ST_FLUSH, rem_q != 3'd0)
	`U8LD_ASSERT_NOW(a_pending_len, cnt_q != 2'd0, (len_q >= u8ld_pkg::LEN_TWO) && (len_q <= u8ld_pkg::LEN_FOUR) && ({1'b0, cnt_q} < len_q))
	`U8LD_ASSERT_NEXT(a_eot_flush, byte_valid && !byte_stall && byte_item.end_of_text, state_q == u8ld_pkg::ST_FLUSH && cnt_q == 2'd0)

endmodule
